// File: rtl/lrs_pkg.sv
// lrs_pkg: shared word types and sequencer state codes for the range add/sum tree
// used by lazy_range_add_sum_tree_core and the bench
package lrs_pkg;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_SUM = 1'b1;

   typedef struct packed {
      logic               command;
      logic [10:0]        left_index;
      logic [10:0]        right_index;
      logic signed [31:0] add_value;
   } req_word_type;

   typedef struct packed {
      logic signed [63:0] range_sum;
      logic               bad_range;
   } rsp_word_type;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_SETUP = 7'b0000100,
      ST_RD    = 7'b0001000,
      ST_WR    = 7'b0010000,
      ST_MUL   = 7'b0100000,
      ST_FIN   = 7'b1000000
   } state_type;

endpackage

// File: rtl/lrs_ram.sv
// lrs_ram: generic single-write, single-read ram with registered read data
// depends on nothing
module lrs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/lazy_range_add_sum_tree_core.sv
// lazy_range_add_sum_tree_core: range add / range sum over LEAVES positions.
// Requests are handled one word at a time: a new word is taken only in the idle state;
// each memory step is a read state and then a write state (on a query the write state accumulates).
// Reset: synchronous; a clearing pass zeroes every address of both memories,
// no request word is taken meanwhile; leaf_count resets to 1024.
// Depends on lrs_pkg and lrs_ram.
module lazy_range_add_sum_tree_core
   import lrs_pkg::*;
#(
   parameter int LEAVES = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word,
   input  logic         csr_write_en,
   input  logic [10:0]  csr_write_data
);

   // two difference trees: d[i] and i*d[i], prefix(x) = (x+1)*S1 - S2
   localparam int DEPTH = LEAVES + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = AW + 1;
   localparam int CW    = (PW > 11) ? PW : 11;
   localparam logic [PW-1:0] LEAF_TOP = PW'(LEAVES);

   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [10:0]        leaf_count_ff;
   logic               cmd_ff, cmd_in;
   logic               phase_ff, phase_in;
   logic               bad_ff, bad_in;
   logic [10:0]        left_ff, left_in, right_ff, right_in;
   logic signed [31:0] value_ff, value_in;
   logic [PW-1:0]      pos_ff, pos_in, idx_ff, idx_in;
   logic [63:0]        d1_ff, d1_in, d2_ff, d2_in;
   logic [63:0]        s1_ff, s1_in, s2_ff, s2_in;
   logic [63:0]        prod_ff, prod_in;
   logic [63:0]        acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [63:0]        wr1, wr2, rd1, rd2;
   logic [PW-1:0]      lowbit, setup_pos, pos_plus;
   logic [CW-1:0]      lim, l_ext, r_ext;
   logic               range_bad, accept;
   logic signed [PW+32:0] pv;
   logic [63:0]        pv_ext, v_ext, part;

   lrs_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram_d (
      .clock, .wr_en, .wr_addr, .wr_data(wr1), .rd_addr(idx_ff[AW-1:0]), .rd_data(rd1)
   );
   lrs_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram_id (
      .clock, .wr_en, .wr_addr, .wr_data(wr2), .rd_addr(idx_ff[AW-1:0]), .rd_data(rd2)
   );

   // bounds check against min(leaf_count, LEAVES)
   always_comb begin
      l_ext = CW'(req_word.left_index);
      r_ext = CW'(req_word.right_index);
      lim   = (CW'(leaf_count_ff) < CW'(LEAF_TOP)) ? CW'(leaf_count_ff) : CW'(LEAF_TOP);
      range_bad = (l_ext == '0) || (l_ext > r_ext) || (r_ext > lim);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign lowbit    = idx_ff & (~idx_ff + PW'(1));
   assign pos_plus  = pos_ff + PW'(1);

   // update point / prefix point for the current phase
   always_comb begin
      if (cmd_ff == CMD_ADD) begin
         setup_pos = phase_ff ? (PW'(right_ff) + PW'(1)) : PW'(left_ff);
      end else begin
         setup_pos = phase_ff ? (PW'(left_ff) - PW'(1)) : PW'(right_ff);
      end
      pv     = $signed({1'b0, setup_pos}) * value_ff;
      pv_ext = {{(31 - PW){pv[PW+32]}}, pv};
      v_ext  = {{32{value_ff[31]}}, value_ff};
      part   = prod_ff - s2_ff;
   end

   // memory write data
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr1     = rd1 + d1_ff;
      wr2     = rd2 + d2_ff;
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr1     = '0;
         wr2     = '0;
      end else if (state_ff == ST_WR && cmd_ff == CMD_ADD) begin
         wr_en = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      cmd_in = cmd_ff;
      phase_in = phase_ff;
      bad_in = bad_ff;
      left_in = left_ff;
      right_in = right_ff;
      value_in = value_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      d1_in = d1_ff;
      d2_in = d2_ff;
      s1_in = s1_ff;
      s2_in = s2_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(LEAVES)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_word.command;
               left_in  = req_word.left_index;
               right_in = req_word.right_index;
               value_in = req_word.add_value;
               phase_in = 1'b0;
               bad_in   = range_bad;
               acc_in   = '0;
               state_in = range_bad ? ST_FIN : ST_SETUP;
            end
         end
         ST_SETUP: begin
            pos_in = setup_pos;
            idx_in = setup_pos;
            s1_in  = '0;
            s2_in  = '0;
            d1_in  = phase_ff ? -v_ext : v_ext;
            d2_in  = phase_ff ? -pv_ext : pv_ext;
            if (setup_pos == '0) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_WR;
         end
         ST_WR: begin
            if (cmd_ff == CMD_ADD) begin
               idx_in = idx_ff + lowbit;
               if (idx_in > LEAF_TOP) begin
                  if (!phase_ff && PW'(right_ff) < LEAF_TOP) begin
                     phase_in = 1'b1;
                     state_in = ST_SETUP;
                  end else begin
                     state_in = ST_FIN;
                  end
               end else begin
                  state_in = ST_RD;
               end
            end else begin
               s1_in  = s1_ff + rd1;
               s2_in  = s2_ff + rd2;
               idx_in = idx_ff - lowbit;
               state_in = (idx_in == '0) ? ST_MUL : ST_RD;
            end
         end
         ST_MUL: begin
            // product registered, combined next cycle in the finish step
            prod_in  = s1_ff * {{(64 - PW){1'b0}}, pos_plus};
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!bad_ff && cmd_ff == CMD_SUM && !phase_ff) begin
               acc_in   = part;
               phase_in = 1'b1;
               state_in = ST_SETUP;
            end else if (!rsp_valid_ff || rsp_ready) begin
               if (!bad_ff && cmd_ff == CMD_SUM) begin
                  acc_in = acc_ff - part;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         leaf_count_ff <= 11'd1024;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            leaf_count_ff <= csr_write_data;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      phase_ff <= phase_in;
      bad_ff   <= bad_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      value_ff <= value_in;
      pos_ff   <= pos_in;
      idx_ff   <= idx_in;
      d1_ff    <= d1_in;
      d2_ff    <= d2_in;
      s1_ff    <= s1_in;
      s2_ff    <= s2_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
   end

   // output word
   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN && state_in == ST_IDLE) begin
         rsp_word.range_sum <= acc_in;
         rsp_word.bad_range <= bad_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // no word taken during the clearing pass
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("word accepted during clear");

   // a memory step never targets index zero or an index above LEAVES
   a_idx_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD |-> idx_ff != '0 && idx_ff <= LEAF_TOP)
      else $error("walk index out of range");

   // a rejected word never reports a sum
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word.bad_range |-> rsp_word.range_sum == '0)
      else $error("bad range with nonzero sum");

   // no memory write on a query
   a_query_ro: assert property (@(posedge clock) disable iff (reset)
      wr_en && state_ff != ST_CLEAR |-> cmd_ff == CMD_ADD && !bad_ff)
      else $error("write on query");

endmodule
